// ===== rtl/switcher_tally_packet_receiver_assert.svh =====
// Assertion macros used by the tally packet receiver queue module.
`ifndef SWITCHER_TALLY_PACKET_RECEIVER_ASSERT_SVH
`define SWITCHER_TALLY_PACKET_RECEIVER_ASSERT_SVH
// Checks that b holds in the same cycle as a, outside reset.
`define STPR_ASSERT_IMPLY(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("stpr assertion failed");
// Checks that b holds in the cycle after a, outside reset.
`define STPR_ASSERT_NEXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("stpr assertion failed");
`endif

// ===== rtl/stpr_pkg.sv =====
// Types and constants shared by the tally packet receiver modules.
package stpr_pkg;
   localparam int MAX_CHANNELS     = 20;
   localparam int MAX_PACKET_BYTES = 2048;
   localparam int TALLY_W          = 40;
   localparam int OFFSET_W         = $clog2(MAX_PACKET_BYTES) + 1;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_W      = 1;
   localparam int QUEUE_CNT_W      = 2;

   localparam logic [31:0] NAME_TLC  = 32'h5F546C43;
   localparam logic [31:0] NAME_PRGI = 32'h50726749;
   localparam logic [31:0] NAME_PRVI = 32'h50727649;
   localparam logic [31:0] NAME_TLIN = 32'h546C496E;
   localparam logic [31:0] NAME_INCM = 32'h496E436D;

   localparam int FLAG_ACK_BIT    = 0;
   localparam int FLAG_HELLO_BIT  = 1;
   localparam int FLAG_RESEND_BIT = 2;

   localparam logic [1:0] OP_BYTE       = 2'd0;
   localparam logic [1:0] OP_CONNECT    = 2'd1;
   localparam logic [1:0] OP_DISCONNECT = 2'd2;

   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_CONNECT    = 2'd1,
      KIND_DISCONNECT = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } item_type;

   typedef enum logic [3:0] {
      LINK_DISCONNECTED = 4'b0001,
      LINK_CONNECTING   = 4'b0010,
      LINK_CONNECTED    = 4'b0100,
      LINK_READY        = 4'b1000
   } link_type;

   function automatic logic [1:0] link_code(input link_type s);
      logic [1:0] c;
      case (s)
         LINK_CONNECTING: c = 2'd1;
         LINK_CONNECTED:  c = 2'd2;
         LINK_READY:      c = 2'd3;
         default:         c = 2'd0;
      endcase
      return c;
   endfunction
endpackage

// ===== rtl/stpr_queue.sv =====
// Front end: accepts input transactions, classifies them and queues them.
`include "switcher_tally_packet_receiver_assert.svh"
module stpr_queue import stpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       q_valid,
   output item_type   q_item,
   input  logic       q_pop
);
   item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                     push, keep;
   item_type                 item;

   assign req_ready = (cnt_ff < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = mem_ff[rd_ff];

   always_comb begin
      item.data = req_data_byte;
      item.last = req_last_byte;
      keep      = 1'b1;
      case (req_op)
         OP_BYTE:       item.kind = KIND_BYTE;
         OP_CONNECT:    item.kind = KIND_CONNECT;
         OP_DISCONNECT: item.kind = KIND_DISCONNECT;
         default: begin
            // The unused opcode has no effect, so it is dropped here.
            item.kind = KIND_BYTE;
            keep      = 1'b0;
         end
      endcase
      push  = req_valid && req_ready && keep;
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_in = (rd_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= item;
      end
   end

   `STPR_ASSERT_IMPLY(a_count_bound, 1'b1, cnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `STPR_ASSERT_IMPLY(a_pop_nonempty, q_pop, cnt_ff != '0)
   `STPR_ASSERT_NEXT(a_push_grows, push && !q_pop, cnt_ff == $past(cnt_ff) + 1'b1)
endmodule

// ===== rtl/stpr_engine.sv =====
// Back end: header judgement, command walker, link state and result register.
module stpr_engine import stpr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic               rsp_send_ack,
   output logic [15:0]        rsp_ack_session,
   output logic [15:0]        rsp_ack_packet_id,
   output logic [1:0]         rsp_link_state,
   output logic [TALLY_W-1:0] rsp_tally_bits,
   output logic               rsp_tally_event,
   output logic [15:0]        rsp_program_source,
   output logic [15:0]        rsp_preview_source,
   output logic [7:0]         rsp_camera_count
);
   logic [4:0]          limit_ff;
   link_type            phase_ff, phase_in;
   logic [15:0]         session_ff, session_in, newest_ff, newest_in, highest_ff, highest_in;
   logic [7:0]          cams_ff, cams_in;
   logic [TALLY_W-1:0]  tally_ff, tally_in, staged_ff, staged_in;
   logic [15:0]         prog_ff, prog_in, prev_ff, prev_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [4:0]          flags_ff, flags_in;
   logic [15:0]         sid_ff, sid_in, pid_ff, pid_in;
   logic                active_ff, active_in;
   logic [OFFSET_W-1:0] pos_ff, pos_in;
   logic [15:0]         len_ff, len_in, cap_ff, cap_in;
   logic [31:0]         name_ff, name_in;
   logic                acc_ff, acc_in, ack_ff, ack_in, event_ff, event_in;
   logic [15:0]         asess_ff, asess_in, aid_ff, aid_in;
   logic                rv_ff, rv_in;
   logic                o_acc_ff, o_acc_in, o_ack_ff, o_ack_in, o_ev_ff, o_ev_in;
   logic [15:0]         o_sess_ff, o_sess_in, o_id_ff, o_id_in;
   logic [1:0]          o_link_ff, o_link_in;
   logic [TALLY_W-1:0]  o_tally_ff, o_tally_in;
   logic [15:0]         o_prog_ff, o_prog_in, o_prev_ff, o_prev_in;
   logic [7:0]          o_cams_ff, o_cams_in;

   always_comb begin
      logic                start, skip;
      logic [7:0]          b;
      logic [15:0]         latch, dlen, cnt;
      logic [OFFSET_W-1:0] pos, d, chan;
      logic [TALLY_W-1:0]  mask;
      phase_in = phase_ff;   session_in = session_ff; newest_in = newest_ff;
      highest_in = highest_ff; cams_in = cams_ff; tally_in = tally_ff;
      staged_in = staged_ff; prog_in = prog_ff; prev_in = prev_ff;
      off_in = off_ff; flags_in = flags_ff; sid_in = sid_ff; pid_in = pid_ff;
      active_in = active_ff; pos_in = pos_ff; len_in = len_ff; cap_in = cap_ff;
      name_in = name_ff; acc_in = acc_ff; ack_in = ack_ff; event_in = event_ff;
      asess_in = asess_ff; aid_in = aid_ff;
      o_acc_in = o_acc_ff; o_ack_in = o_ack_ff; o_ev_in = o_ev_ff;
      o_sess_in = o_sess_ff; o_id_in = o_id_ff; o_link_in = o_link_ff;
      o_tally_in = o_tally_ff; o_prog_in = o_prog_ff; o_prev_in = o_prev_ff;
      o_cams_in = o_cams_ff;
      start = 1'b0; skip = 1'b0;
      b = q_item.data;
      pos = pos_ff;
      d = pos_ff - OFFSET_W'(8);
      chan = pos_ff - OFFSET_W'(10);
      latch = '0; dlen = '0; cnt = '0; mask = '0;

      q_pop = q_valid && (!rv_ff || rsp_ready);
      rv_in = rv_ff && !rsp_ready;

      if (q_pop) begin
         case (q_item.kind)
            KIND_CONNECT: begin
               if (phase_ff == LINK_DISCONNECTED) begin
                  session_in = '0; newest_in = '0; highest_in = '0; cams_in = '0;
                  tally_in = '0; prog_in = '0; prev_in = '0;
                  phase_in = LINK_CONNECTING;
               end
               start = 1'b1;
            end
            KIND_DISCONNECT: begin
               phase_in = LINK_DISCONNECTED;
               start = 1'b1;
            end
            KIND_BYTE: begin
               if (off_ff < OFFSET_W'(MAX_PACKET_BYTES)) begin
                  off_in = off_ff + 1'b1;
                  if (off_ff == OFFSET_W'(0)) flags_in = b[7:3];
                  if (off_ff == OFFSET_W'(2)) sid_in[15:8] = b;
                  if (off_ff == OFFSET_W'(3)) sid_in[7:0] = b;
                  if (off_ff == OFFSET_W'(10)) pid_in[15:8] = b;
                  if (off_ff == OFFSET_W'(11)) pid_in[7:0] = b;
                  if (off_ff == OFFSET_W'(11)) begin
                     // Header judgement on the final header byte.
                     latch = (session_ff == '0 && sid_in != '0) ? sid_in : session_ff;
                     if (phase_ff != LINK_DISCONNECTED) begin
                        if (flags_in[FLAG_HELLO_BIT] && phase_ff == LINK_CONNECTING) begin
                           acc_in = 1'b1; ack_in = 1'b1;
                           asess_in = sid_in; aid_in = pid_in;
                           phase_in = LINK_CONNECTED;
                        end else begin
                           session_in = latch;
                           if (!(latch != '0 && sid_in != '0 && sid_in != latch)) begin
                              acc_in = 1'b1;
                              if (phase_ff == LINK_READY && pid_in != '0) begin
                                 if (pid_in <= newest_ff) begin
                                    skip = 1'b1;
                                 end else begin
                                    newest_in = pid_in;
                                    if (flags_in[FLAG_RESEND_BIT]) skip = 1'b1;
                                 end
                              end
                              if (flags_in[FLAG_ACK_BIT] && latch != '0) begin
                                 ack_in = 1'b1; asess_in = latch; aid_in = pid_in;
                              end
                              if (!skip) begin
                                 if (pid_in > highest_ff) highest_in = pid_in;
                                 active_in = 1'b1;
                                 pos_in = '0;
                              end
                           end
                        end
                     end
                  end else if (off_ff > OFFSET_W'(11) && active_ff) begin
                     // Command walker: fields are staged until the command's last byte.
                     if (pos == OFFSET_W'(0)) begin
                        len_in = {b, 8'h00}; name_in = '0; cap_in = '0; staged_in = '0;
                     end else if (pos == OFFSET_W'(1)) begin
                        len_in = {len_ff[15:8], b};
                     end else if (pos >= OFFSET_W'(4) && pos < OFFSET_W'(8)) begin
                        name_in = {name_ff[23:0], b};
                     end else if (pos >= OFFSET_W'(8)) begin
                        if (name_ff == NAME_TLIN) begin
                           if (d < OFFSET_W'(2)) begin
                              cap_in = {cap_ff[7:0], b};
                           end else if (pos < OFFSET_W'(10 + MAX_CHANNELS)) begin
                              for (int i = 0; i < MAX_CHANNELS; i++) begin
                                 if (chan == OFFSET_W'(i)) staged_in[2*i +: 2] = b[1:0];
                              end
                           end
                        end else if (name_ff == NAME_TLC) begin
                           if (d == OFFSET_W'(4)) cap_in = {8'h00, b};
                        end else if (name_ff == NAME_PRGI || name_ff == NAME_PRVI) begin
                           if (d == OFFSET_W'(2) || d == OFFSET_W'(3)) cap_in = {cap_ff[7:0], b};
                        end
                     end
                     if (pos == OFFSET_W'(1) && len_in < 16'd8) begin
                        active_in = 1'b0;
                     end else if (pos >= OFFSET_W'(7) &&
                                  16'(pos) + 16'd1 == len_in) begin
                        dlen = len_in - 16'd8;
                        if (name_in == NAME_TLC) begin
                           if (dlen >= 16'd5) cams_in = cap_in[7:0];
                        end else if (name_in == NAME_PRGI) begin
                           if (dlen >= 16'd4) prog_in = cap_in;
                        end else if (name_in == NAME_PRVI) begin
                           if (dlen >= 16'd4) prev_in = cap_in;
                        end else if (name_in == NAME_TLIN) begin
                           if (dlen >= 16'd2) begin
                              cnt = cap_in;
                              if (cnt > dlen - 16'd2) cnt = dlen - 16'd2;
                              if (cnt > 16'(MAX_CHANNELS)) cnt = 16'(MAX_CHANNELS);
                              if (limit_ff != '0 && cnt > 16'(limit_ff)) cnt = 16'(limit_ff);
                              if (cams_ff != '0 && cnt > 16'(cams_ff)) cnt = 16'(cams_ff);
                              for (int i = 0; i < MAX_CHANNELS; i++) begin
                                 mask[2*i +: 2] = {2{16'(i) < cnt}};
                              end
                              tally_in = staged_in & mask;
                              if ((staged_in & mask) != '0) event_in = 1'b1;
                           end
                        end else if (name_in == NAME_INCM) begin
                           phase_in = LINK_READY;
                        end
                        pos_in = '0;
                        staged_in = '0;
                     end else begin
                        pos_in = pos + 1'b1;
                     end
                  end
               end
               if (q_item.last) begin
                  rv_in = 1'b1;
                  o_acc_in = acc_in; o_ack_in = ack_in;
                  o_sess_in = ack_in ? asess_in : '0;
                  o_id_in = ack_in ? aid_in : '0;
                  o_link_in = link_code(phase_in);
                  o_tally_in = tally_in; o_ev_in = event_in;
                  o_prog_in = prog_in; o_prev_in = prev_in; o_cams_in = cams_in;
                  start = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (start) begin
         off_in = '0; flags_in = '0; sid_in = '0; pid_in = '0; staged_in = '0;
         active_in = 1'b0; pos_in = '0; len_in = '0; name_in = '0; cap_in = '0;
         acc_in = 1'b0; ack_in = 1'b0; asess_in = '0; aid_in = '0; event_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0; phase_ff <= LINK_DISCONNECTED; session_ff <= '0;
         newest_ff <= '0; highest_ff <= '0; cams_ff <= '0; tally_ff <= '0;
         staged_ff <= '0; prog_ff <= '0; prev_ff <= '0; off_ff <= '0;
         flags_ff <= '0; sid_ff <= '0; pid_ff <= '0; active_ff <= 1'b0;
         pos_ff <= '0; len_ff <= '0; cap_ff <= '0; name_ff <= '0;
         acc_ff <= 1'b0; ack_ff <= 1'b0; event_ff <= 1'b0;
         asess_ff <= '0; aid_ff <= '0; rv_ff <= 1'b0;
      end else begin
         if (csr_write_enable) limit_ff <= csr_write_data;
         phase_ff <= phase_in; session_ff <= session_in; newest_ff <= newest_in;
         highest_ff <= highest_in; cams_ff <= cams_in; tally_ff <= tally_in;
         staged_ff <= staged_in; prog_ff <= prog_in; prev_ff <= prev_in;
         off_ff <= off_in; flags_ff <= flags_in; sid_ff <= sid_in; pid_ff <= pid_in;
         active_ff <= active_in; pos_ff <= pos_in; len_ff <= len_in;
         cap_ff <= cap_in; name_ff <= name_in; acc_ff <= acc_in; ack_ff <= ack_in;
         event_ff <= event_in; asess_ff <= asess_in; aid_ff <= aid_in;
         rv_ff <= rv_in;
      end
      o_acc_ff <= o_acc_in; o_ack_ff <= o_ack_in; o_ev_ff <= o_ev_in;
      o_sess_ff <= o_sess_in; o_id_ff <= o_id_in; o_link_ff <= o_link_in;
      o_tally_ff <= o_tally_in; o_prog_ff <= o_prog_in; o_prev_ff <= o_prev_in;
      o_cams_ff <= o_cams_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_accepted       = o_acc_ff;
   assign rsp_send_ack       = o_ack_ff;
   assign rsp_ack_session    = o_sess_ff;
   assign rsp_ack_packet_id  = o_id_ff;
   assign rsp_link_state     = o_link_ff;
   assign rsp_tally_bits     = o_tally_ff;
   assign rsp_tally_event    = o_ev_ff;
   assign rsp_program_source = o_prog_ff;
   assign rsp_preview_source = o_prev_ff;
   assign rsp_camera_count   = o_cams_ff;
endmodule

// ===== rtl/switcher_tally_packet_receiver.sv =====
// Top level of the switcher tally packet receiver.
// Usage: the req channel carries one transaction per datagram byte, or a connect
// or disconnect event, selected by req_op. The rsp channel returns one transaction
// at the byte marked req_last_byte, carrying the packet verdict, acknowledge ids,
// link state and the current tally, source and camera-count values.
// The csr port writes the camera limit; the user must do so only while the block is
// idle, and the block itself does not enforce it. The final byte waits in the input
// queue until the execution unit pops it and loads its result register, which
// raises rsp_valid.
// Throughput: one transaction per cycle while the result register is free or being
// taken; the execution unit walks the header and command bytes.
// When the receiver holds rsp_ready low the result register keeps its value, the
// execution unit stops, and the two-entry queue fills before req_ready drops.
// Reset clears the link to disconnected, all ids, tally and source values and the
// camera limit; the queue and the result register are emptied.
module switcher_tally_packet_receiver import stpr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic               rsp_send_ack,
   output logic [15:0]        rsp_ack_session,
   output logic [15:0]        rsp_ack_packet_id,
   output logic [1:0]         rsp_link_state,
   output logic [TALLY_W-1:0] rsp_tally_bits,
   output logic               rsp_tally_event,
   output logic [15:0]        rsp_program_source,
   output logic [15:0]        rsp_preview_source,
   output logic [7:0]         rsp_camera_count,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data
);
   // The queue decouples byte acceptance from execution.
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   stpr_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   // The engine carries out each queued transaction and holds the result.
   stpr_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_send_ack       (rsp_send_ack),
      .rsp_ack_session    (rsp_ack_session),
      .rsp_ack_packet_id  (rsp_ack_packet_id),
      .rsp_link_state     (rsp_link_state),
      .rsp_tally_bits     (rsp_tally_bits),
      .rsp_tally_event    (rsp_tally_event),
      .rsp_program_source (rsp_program_source),
      .rsp_preview_source (rsp_preview_source),
      .rsp_camera_count   (rsp_camera_count)
   );
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the switcher tally packet receiver.
`timescale 1ns / 1ps

module tb import stpr_pkg::*; ;

   // The opcode value that the block has to ignore.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Cycles without any transaction before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 5000;
   // Cycles from the last result to a quiet block, taken with some margin.
   localparam int DRAIN_CYCLES = 8;
   // Random byte transactions per configuration phase.
   localparam int PHASE_ITEMS = 290;

   // One expected result, plus values typed into the directed table.
   typedef struct {
      bit        accepted;
      bit        send_ack;
      bit [15:0] ack_session;
      bit [15:0] ack_packet_id;
      bit [1:0]  link_state;
      bit [39:0] tally_bits;
      bit        tally_event;
      bit [15:0] program_source;
      bit [15:0] preview_source;
      bit [7:0]  camera_count;
      bit        pinned;
      bit        pin_accepted;
      bit [1:0]  pin_link;
   } packet_status_type;

   // One row of the directed stimulus table.
   typedef struct {
      logic [1:0] op;
      logic [7:0] data;
      bit         last;
      bit         pinned;
      bit         pin_accepted;
      bit [1:0]   pin_link;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op = OP_BYTE;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_accepted;
   logic               rsp_send_ack;
   logic [15:0]        rsp_ack_session;
   logic [15:0]        rsp_ack_packet_id;
   logic [1:0]         rsp_link_state;
   logic [TALLY_W-1:0] rsp_tally_bits;
   logic               rsp_tally_event;
   logic [15:0]        rsp_program_source;
   logic [15:0]        rsp_preview_source;
   logic [7:0]         rsp_camera_count;
   logic               csr_write_enable = 1'b0;
   logic [4:0]         csr_write_data = 5'd0;

   switcher_tally_packet_receiver u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_send_ack       (rsp_send_ack),
      .rsp_ack_session    (rsp_ack_session),
      .rsp_ack_packet_id  (rsp_ack_packet_id),
      .rsp_link_state     (rsp_link_state),
      .rsp_tally_bits     (rsp_tally_bits),
      .rsp_tally_event    (rsp_tally_event),
      .rsp_program_source (rsp_program_source),
      .rsp_preview_source (rsp_preview_source),
      .rsp_camera_count   (rsp_camera_count),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // The clock runs with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: the link, the ids, the reported values and the camera limit.
   bit [4:0]  limit_reg;
   bit [1:0]  link_now;
   bit [15:0] session_now;
   bit [15:0] newest_id;
   bit [15:0] top_remote_id;
   bit [7:0]  cams_now;
   bit [39:0] tally_now;
   bit [15:0] program_now;
   bit [15:0] preview_now;

   // Per-datagram state: byte position, header fields and the command walker.
   int unsigned offset_now;
   bit [4:0]    hdr_flags;
   bit [15:0]   hdr_session;
   bit [15:0]   hdr_packet_id;
   bit [39:0]   staged_bits;
   bit          walk_on;
   int unsigned walk_pos;
   int unsigned walk_len;
   bit [31:0]   walk_name;
   bit [15:0]   walk_capture;
   packet_status_type verdict;

   packet_status_type status_q[$];

   int errors = 0;
   int idle_cycles = 0;

   // Stimulus control shared by the sender and the receiver.
   bit        no_idle = 1'b0;
   bit        hold_request = 1'b0;
   int        hold_left = 0;
   int        stall_left = 0;
   int        rcv_roll;
   bit        drive_pinned = 1'b0;
   bit        drive_pin_accepted = 1'b0;
   bit [1:0]  drive_pin_link = 2'd0;

   // Generator state: the session and packet id that the far end is using.
   bit [15:0] gen_session;
   bit [15:0] gen_packet_id;
   bit        gen_need_hello;
   int        phase_items;

   stim_row_type stim_rows [20];

   // Adds one byte at the end of a byte list.
   task automatic append_byte(ref logic [7:0] q[$], input logic [7:0] v);
      q.insert(q.size(), v);
   endtask

   task automatic new_datagram();
      offset_now    = 0;
      hdr_flags     = '0;
      hdr_session   = '0;
      hdr_packet_id = '0;
      staged_bits   = '0;
      walk_on       = 1'b0;
      walk_pos      = 0;
      walk_len      = 0;
      walk_name     = '0;
      walk_capture  = '0;
      verdict       = '{default: 0};
   endtask

   task automatic clear_link();
      session_now   = '0;
      newest_id     = '0;
      top_remote_id = '0;
      cams_now      = '0;
      tally_now     = '0;
      program_now   = '0;
      preview_now   = '0;
   endtask

   // Decides the fate of the packet once its twelfth byte has arrived.
   task automatic judge_header();
      bit skip;
      skip = 1'b0;
      if (link_now == 2'd0) return;
      if (hdr_flags[FLAG_HELLO_BIT] && link_now == 2'd1) begin
         verdict.accepted      = 1'b1;
         verdict.send_ack      = 1'b1;
         verdict.ack_session   = hdr_session;
         verdict.ack_packet_id = hdr_packet_id;
         link_now              = 2'd2;
         return;
      end
      if (session_now == 16'd0 && hdr_session != 16'd0) session_now = hdr_session;
      if (session_now != 16'd0 && hdr_session != 16'd0 && hdr_session != session_now) return;
      verdict.accepted = 1'b1;
      // Once ready, old ids and resends are accepted, and acknowledged if asked, but not parsed.
      if (link_now == 2'd3 && hdr_packet_id != 16'd0) begin
         if (hdr_packet_id <= newest_id) begin
            skip = 1'b1;
         end else begin
            newest_id = hdr_packet_id;
            if (hdr_flags[FLAG_RESEND_BIT]) skip = 1'b1;
         end
      end
      if (hdr_flags[FLAG_ACK_BIT] && session_now != 16'd0) begin
         verdict.send_ack      = 1'b1;
         verdict.ack_session   = session_now;
         verdict.ack_packet_id = hdr_packet_id;
      end
      if (skip) return;
      if (hdr_packet_id > top_remote_id) top_remote_id = hdr_packet_id;
      walk_on  = 1'b1;
      walk_pos = 0;
   endtask

   // Applies a command whose final byte has just arrived.
   task automatic commit_command();
      int unsigned data_len;
      int unsigned count;
      logic [63:0] keep;
      data_len = walk_len - 8;
      case (walk_name)
         NAME_TLC:  if (data_len >= 5) cams_now = walk_capture[7:0];
         NAME_PRGI: if (data_len >= 4) program_now = walk_capture;
         NAME_PRVI: if (data_len >= 4) preview_now = walk_capture;
         NAME_TLIN: begin
            if (data_len >= 2) begin
               count = 32'(walk_capture);
               if (count > data_len - 2) count = data_len - 2;
               if (count > MAX_CHANNELS) count = MAX_CHANNELS;
               if (limit_reg != 0 && count > limit_reg) count = 32'(limit_reg);
               if (cams_now != 0 && count > cams_now) count = 32'(cams_now);
               keep      = (64'd1 << (2 * count)) - 64'd1;
               tally_now = staged_bits & keep[39:0];
               if (tally_now != 40'd0) verdict.tally_event = 1'b1;
            end
         end
         NAME_INCM: link_now = 2'd3;
         default: ;
      endcase
   endtask

   task automatic walk_byte(input logic [7:0] b);
      int unsigned pos;
      int unsigned d;
      pos = walk_pos;
      if (pos == 0) begin
         walk_len     = {16'h0000, b, 8'h00};
         walk_name    = '0;
         walk_capture = '0;
         staged_bits  = '0;
      end else if (pos == 1) begin
         walk_len = walk_len | 32'(b);
         // A length that cannot hold the command header ends the parsing.
         if (walk_len < 8) begin
            walk_on = 1'b0;
            return;
         end
      end else if (pos >= 4 && pos < 8) begin
         walk_name = {walk_name[23:0], b};
      end else if (pos >= 8) begin
         d = pos - 8;
         if (walk_name == NAME_TLIN) begin
            if (d < 2) walk_capture = {walk_capture[7:0], b};
            else if (d - 2 < MAX_CHANNELS) staged_bits |= 40'(b[1:0]) << (2 * (d - 2));
         end else if (walk_name == NAME_TLC) begin
            if (d == 4) walk_capture = {8'h00, b};
         end else if (walk_name == NAME_PRGI || walk_name == NAME_PRVI) begin
            if (d == 2 || d == 3) walk_capture = {walk_capture[7:0], b};
         end
      end
      if (pos >= 7 && pos + 1 == walk_len) begin
         commit_command();
         walk_pos    = 0;
         staged_bits = '0;
      end else begin
         walk_pos = pos + 1;
      end
   endtask

   // Advances the predictor by one accepted transaction and queues its result.
   task automatic absorb_item(input logic [1:0] op, input logic [7:0] b, input logic last,
                              input bit pin, input bit pin_acc, input bit [1:0] pin_link);
      int unsigned off;
      packet_status_type r;
      if (op == OP_CONNECT) begin
         // A connect while the link is up is ignored, but still drops the datagram.
         if (link_now == 2'd0) begin
            clear_link();
            link_now = 2'd1;
         end
         new_datagram();
         return;
      end
      if (op == OP_DISCONNECT) begin
         link_now = 2'd0;
         new_datagram();
         return;
      end
      if (op != OP_BYTE) return;
      off = offset_now;
      // Bytes past the maximum packet size are dropped until the last one.
      if (off < MAX_PACKET_BYTES) begin
         offset_now = off + 1;
         case (off)
            0:  hdr_flags = b[7:3];
            2:  hdr_session[15:8] = b;
            3:  hdr_session[7:0] = b;
            10: hdr_packet_id[15:8] = b;
            11: hdr_packet_id[7:0] = b;
            default: ;
         endcase
         if (off == 11) judge_header();
         else if (off > 11 && walk_on) walk_byte(b);
      end
      if (!last) return;
      r = verdict;
      if (!r.send_ack) begin
         r.ack_session   = '0;
         r.ack_packet_id = '0;
      end
      r.link_state     = link_now;
      r.tally_bits     = tally_now;
      r.program_source = program_now;
      r.preview_source = preview_now;
      r.camera_count   = cams_now;
      r.pinned         = pin;
      r.pin_accepted   = pin_acc;
      r.pin_link       = pin_link;
      status_q.insert(status_q.size(), r);
      new_datagram();
   endtask

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
      errors++;
   endtask

   task automatic check_field(input string field, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report(field, got, want);
   endtask

   // Both channels are sampled at the rising edge. Inputs only change at the falling edge,
   // so the values seen here are the ones the block sees.
   always @(posedge clock) begin
      packet_status_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (req_valid && req_ready)
            absorb_item(req_op, req_data_byte, req_last_byte,
                        drive_pinned, drive_pin_accepted, drive_pin_link);
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               report("unexpected result", 64'd1, 64'd0);
            end else begin
               want = status_q.pop_front();
               check_field("accepted", rsp_accepted, want.accepted);
               check_field("send_ack", rsp_send_ack, want.send_ack);
               check_field("ack_session", rsp_ack_session, want.ack_session);
               check_field("ack_packet_id", rsp_ack_packet_id, want.ack_packet_id);
               check_field("link_state", rsp_link_state, want.link_state);
               check_field("tally_bits", rsp_tally_bits, want.tally_bits);
               check_field("tally_event", rsp_tally_event, want.tally_event);
               check_field("program_source", rsp_program_source, want.program_source);
               check_field("preview_source", rsp_preview_source, want.preview_source);
               check_field("camera_count", rsp_camera_count, want.camera_count);
               // Rows of the directed table also carry values typed in by hand.
               if (want.pinned) begin
                  check_field("accepted (table)", rsp_accepted, want.pin_accepted);
                  check_field("link_state (table)", rsp_link_state, want.pin_link);
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // The receiver stalls at random, mostly briefly and now and then for a long stretch.
   // A hold request from the sender side makes it refuse results until its hold count runs
   // out, which fills the block's queue and stalls its input.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = 200;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else begin
         rcv_roll = $urandom_range(0, 99);
         if (no_idle || rcv_roll < 70) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready  = 1'b0;
            stall_left = (rcv_roll < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
         end
      end
   end

   function automatic int gap_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) return 0;
      if (roll < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one transaction and returns once it has been accepted. Valid is only lowered
   // when a gap follows, so back-to-back transactions keep it high.
   task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic last,
                            input bit pin = 1'b0, input bit pin_acc = 1'b0,
                            input bit [1:0] pin_link = 2'd0);
      int gap;
      gap = gap_cycles();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid          = 1'b1;
      req_op             = op;
      req_data_byte      = data;
      req_last_byte      = last;
      drive_pinned       = pin;
      drive_pin_accepted = pin_acc;
      drive_pin_link     = pin_link;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_BYTE) phase_items++;
   endtask

   // Holds the sender back until every expected result has been delivered.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the camera limit while the block is quiet.
   task automatic write_limit(input bit [4:0] value);
      drain_results();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      limit_reg        = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data   = 5'($urandom_range(0, 31));
   endtask

   // Sends a whole datagram byte by byte, the final one marked as last.
   task automatic send_bytes(input logic [7:0] bytes[$]);
      foreach (bytes[i]) send_item(OP_BYTE, bytes[i], i == bytes.size() - 1);
   endtask

   // Builds one random datagram, mostly well formed, from the far end's point of view.
   task automatic send_random_packet();
      logic [7:0]  pkt[$];
      logic [7:0]  body[$];
      logic [4:0]  flags;
      logic [15:0] sid;
      logic [15:0] pid;
      int          n_cmds;
      int          kind;
      int          dlen;
      int          len;
      int          roll;
      int          cut;
      logic [31:0] name;
      flags = '0;
      if (gen_need_hello || $urandom_range(0, 9) == 0) flags[FLAG_HELLO_BIT] = 1'b1;
      if ($urandom_range(0, 1)) flags[FLAG_ACK_BIT] = 1'b1;
      if ($urandom_range(0, 7) == 0) flags[FLAG_RESEND_BIT] = 1'b1;
      flags[4:3] = 2'($urandom_range(0, 3));
      gen_need_hello = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 82) sid = gen_session;
      else if (roll < 91) sid = 16'd0;
      else sid = 16'($urandom);
      // Packet ids mostly climb; some repeat an old one or are zero.
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         gen_packet_id++;
         pid = gen_packet_id;
      end else if (roll < 92) begin
         pid = gen_packet_id - 16'($urandom_range(0, 3));
      end else begin
         pid = 16'd0;
      end
      append_byte(pkt, {flags, 3'($urandom_range(0, 7))});
      append_byte(pkt, 8'($urandom));
      append_byte(pkt, sid[15:8]);
      append_byte(pkt, sid[7:0]);
      repeat (6) append_byte(pkt, 8'($urandom));
      append_byte(pkt, pid[15:8]);
      append_byte(pkt, pid[7:0]);
      n_cmds = $urandom_range(0, 4);
      repeat (n_cmds) begin
         body.delete();
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1: begin
               name = NAME_TLIN;
               append_byte(body, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
               append_byte(body, 8'($urandom_range(0, 25)));
               repeat ($urandom_range(0, 23)) append_byte(body, 8'($urandom));
            end
            2: begin
               name = NAME_TLC;
               repeat ($urandom_range(3, 7)) append_byte(body, 8'($urandom));
               if (body.size() > 4) body[4] = ($urandom_range(0, 9) == 0)
                                              ? 8'($urandom) : 8'($urandom_range(0, 24));
            end
            3, 4: begin
               name = NAME_PRGI;
               repeat ($urandom_range(3, 6)) append_byte(body, 8'($urandom));
            end
            5, 6: begin
               name = NAME_PRVI;
               repeat ($urandom_range(3, 6)) append_byte(body, 8'($urandom));
            end
            7: begin
               name = NAME_INCM;
               repeat ($urandom_range(0, 2)) append_byte(body, 8'($urandom));
            end
            default: begin
               name = $urandom;
               repeat ($urandom_range(0, 4)) append_byte(body, 8'($urandom));
            end
         endcase
         dlen = body.size();
         len  = 8 + dlen;
         // Now and then the length field is broken, short or just off.
         roll = $urandom_range(0, 99);
         if (roll < 5) len = $urandom_range(0, 7);
         else if (roll < 9) len = len + $urandom_range(1, 3);
         else if (roll < 10) len = $urandom_range(0, 65535);
         append_byte(pkt, len[15:8]);
         append_byte(pkt, len[7:0]);
         append_byte(pkt, 8'($urandom));
         append_byte(pkt, 8'($urandom));
         append_byte(pkt, name[31:24]);
         append_byte(pkt, name[23:16]);
         append_byte(pkt, name[15:8]);
         append_byte(pkt, name[7:0]);
         foreach (body[i]) append_byte(pkt, body[i]);
      end
      // Some datagrams end inside a command, and a few end inside the header.
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         cut = $urandom_range(1, 11);
         while (pkt.size() > cut) void'(pkt.pop_back());
      end else if (roll < 12 && pkt.size() > 13) begin
         cut = $urandom_range(12, pkt.size() - 1);
         while (pkt.size() > cut) void'(pkt.pop_back());
      end
      // A connect or disconnect can break into the middle of a datagram.
      roll = $urandom_range(0, 99);
      if (roll < 3 && pkt.size() > 2) begin
         cut = $urandom_range(1, pkt.size() - 1);
         for (int i = 0; i < cut; i++) send_item(OP_BYTE, pkt[i], 1'b0);
         if ($urandom_range(0, 1)) begin
            send_item(OP_DISCONNECT, 8'($urandom), 1'($urandom));
            send_item(OP_CONNECT, 8'($urandom), 1'($urandom));
            gen_session    = 16'($urandom_range(1, 65535));
            gen_packet_id  = '0;
            gen_need_hello = 1'b1;
         end else begin
            send_item(OP_CONNECT, 8'($urandom), 1'($urandom));
         end
         return;
      end
      send_bytes(pkt);
   endtask

   // Noise between datagrams: unused opcodes, ignored connects and link drops.
   task automatic send_noise();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
      end else if (roll < 6) begin
         send_item(OP_CONNECT, 8'($urandom), 1'($urandom));
      end else if (roll < 8) begin
         send_item(OP_DISCONNECT, 8'($urandom), 1'($urandom));
         // A packet sent while disconnected is always rejected.
         if ($urandom_range(0, 1)) send_random_packet();
         send_item(OP_CONNECT, 8'($urandom), 1'($urandom));
         gen_session    = 16'($urandom_range(1, 65535));
         gen_packet_id  = '0;
         gen_need_hello = 1'b1;
      end
   endtask

   // One datagram that runs past the maximum packet size.
   task automatic send_oversize_packet();
      logic [7:0] pkt[$];
      for (int i = 0; i < MAX_PACKET_BYTES + 40; i++) append_byte(pkt, 8'($urandom));
      pkt[2] = gen_session[15:8];
      pkt[3] = gen_session[7:0];
      send_bytes(pkt);
   endtask

   initial begin
      bit [4:0] limits [6];
      // Directed part: noise, short packets while disconnected, connect, a connect while
      // busy, a hello that brings the link up, and a disconnect.
      stim_rows = '{
         '{OP_UNUSED,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'h00, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'hFF, 1'b1, 1'b1, 1'b0, 2'd0},
         '{OP_CONNECT,    8'hFF, 1'b1, 1'b0, 1'b0, 2'd0},
         '{OP_CONNECT,    8'h00, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'h17, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'h00, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'h00, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'h00, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'hFF, 1'b1, 1'b1, 1'b1, 2'd2},
         '{OP_DISCONNECT, 8'h5A, 1'b0, 1'b0, 1'b0, 2'd0},
         '{OP_BYTE,       8'hA5, 1'b1, 1'b1, 1'b0, 2'd0},
         '{OP_CONNECT,    8'h00, 1'b0, 1'b0, 1'b0, 2'd0}
      };
      limits = '{5'd0, 5'd20, 5'd1, 5'($urandom_range(2, 19)), 5'd20, 5'd0};
      limit_reg      = '0;
      link_now       = 2'd0;
      clear_link();
      new_datagram();
      gen_session    = 16'($urandom_range(1, 65535));
      gen_packet_id  = '0;
      gen_need_hello = 1'b1;

      // Reset is released at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_rows[i])
         send_item(stim_rows[i].op, stim_rows[i].data, stim_rows[i].last,
                   stim_rows[i].pinned, stim_rows[i].pin_accepted, stim_rows[i].pin_link);

      // Random part, one phase per camera limit setting.
      foreach (limits[p]) begin
         write_limit(limits[p]);
         phase_items = 0;
         no_idle = (p == 4);
         // In the fourth phase the receiver holds off while the sender keeps going.
         if (p == 3) hold_request = 1'b1;
         if (p == 1) send_oversize_packet();
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            send_noise();
            send_random_packet();
            // In the third phase, near mid phase, the sender waits for every result to come back.
            if (p == 2 && phase_items >= PHASE_ITEMS / 2 && phase_items < PHASE_ITEMS / 2 + 20)
               drain_results();
         end
      end
      no_idle = 1'b0;

      // Wait for the last results, then give the block time to show any stray one.
      @(negedge clock);
      req_valid = 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (status_q.size() != 0) report("results still owed", status_q.size(), 0);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/stpr_pkg.sv
rtl/stpr_queue.sv
rtl/stpr_engine.sv
rtl/switcher_tally_packet_receiver.sv
tb/tb.sv
